@@ hdl/sorted_unique_max_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted unique max queue: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_MAX_QUEUE_DEFINES_SVH
`define SORTED_UNIQUE_MAX_QUEUE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define SUQ_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("suq check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define SUQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("suq check failed");

`endif

@@ hdl/suq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted unique max queue: package
// Status codes, sequencer states, cell commands and the cell link type.
// ----------------------------------------------------------------------------
`default_nettype none

package suq_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    // cells per registered OR group of the duplicate search
    localparam int unsigned GRP      = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_PUSH,
        CELL_POP
    } t_cell_op;

    // what a cell hands to its right-hand neighbor
    typedef struct packed {
        logic signed [VALUE_W-1:0] entry;
        logic                      lt;
    } t_link;

endpackage

`default_nettype wire

@@ hdl/suq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted unique max queue: storage cell
// Holds one entry, compares it with the pending value, and shifts right on
// insert or left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module suq_cell (
    input  wire logic                              i_clk,
    input  suq_pkg::t_cell_op                      i_op,
    input  wire logic                              i_valid,
    input  wire logic signed [suq_pkg::VALUE_W-1:0] i_value,
    input  suq_pkg::t_link                         i_left,
    input  wire logic signed [suq_pkg::VALUE_W-1:0] i_right_entry,
    output suq_pkg::t_link                         o_link,
    output logic                                   o_eq
);
    import suq_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic                      r_lt;
    logic                      r_eq;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_CMP: begin
                // an empty cell ranks below every value
                r_lt <= !i_valid || (r_entry < i_value);
                r_eq <= i_valid && (r_entry == i_value);
            end
            CELL_PUSH: begin
                if (r_lt) begin
                    r_entry <= i_left.lt ? i_left.entry : i_value;
                end
            end
            CELL_POP: begin
                r_entry <= i_right_entry;
            end
            default: begin
            end
        endcase
    end

    assign o_link.entry = r_entry;
    assign o_link.lt    = r_lt;
    assign o_eq         = r_eq;

endmodule

`default_nettype wire

@@ hdl/sorted_unique_max_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted unique max queue
// Bounded set of distinct signed 32-bit values kept largest first in a row
// of cells; push inserts in place, pop returns the largest.
// ----------------------------------------------------------------------------
// A transaction steps through S_CMP, S_RED and S_DONE: start is taken while
// busy is low, the cells compare in S_CMP, the per-group duplicate flags are
// registered in S_RED, the row updates at the end of S_DONE, and o_done is
// high for the single following cycle with o_status and o_popped_value. busy
// is low again in that cycle, so a new transaction may be started then. The
// result is shown for one cycle only: the receiver cannot stall it and must
// take it when o_done is high. The duplicate search is a two-level OR over
// groups of sixteen cells.
`default_nettype none

`include "sorted_unique_max_queue_defines.svh"

module sorted_unique_max_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_action,
    input  wire logic signed [suq_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_done,
    output logic [suq_pkg::STATUS_W-1:0]            o_status,
    output logic signed [suq_pkg::VALUE_W-1:0]      o_popped_value
);
    import suq_pkg::*;

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned NGRP = (CAPACITY + GRP - 1) / GRP;

    t_state                    r_state, n_state;
    logic                      r_action;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_count, n_count;
    logic [NGRP-1:0]           r_grp, n_grp;
    logic                      r_done, n_done;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_popped, n_popped;
    t_cell_op                  w_op;
    logic                      w_dup;
    logic                      w_full;

    logic [CAPACITY-1:0]        w_valid;
    logic [CAPACITY-1:0]        w_eq;
    logic [NGRP*GRP-1:0]        w_eq_pad;
    t_link                      w_link [CAPACITY];

    // ---- cell row ----
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_link                     w_left;
        logic signed [VALUE_W-1:0] w_right;

        assign w_valid[i] = CW'(i) < r_count;

        if (i == 0) begin : g_head
            assign w_left.entry = '0;
            assign w_left.lt    = 1'b0;
        end else begin : g_body
            assign w_left = w_link[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right = w_link[i].entry;
        end else begin : g_mid
            assign w_right = w_link[i+1].entry;
        end

        suq_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_valid       (w_valid[i]),
            .i_value       (r_value),
            .i_left        (w_left),
            .i_right_entry (w_right),
            .o_link        (w_link[i]),
            .o_eq          (w_eq[i])
        );
    end

    // ---- duplicate search, one register level per group ----
    assign w_eq_pad = (NGRP*GRP)'(w_eq);

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        assign n_grp[g] = |w_eq_pad[g*GRP +: GRP];
    end

    assign w_dup  = |r_grp;
    assign w_full = (r_count == CW'(CAPACITY));

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        r_grp    <= n_grp;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_status = r_status;
        n_popped = r_popped;
        w_op     = CELL_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_op    = CELL_CMP;
                n_state = S_RED;
            end
            S_RED: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_popped = '0;
                if (r_action) begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_POPPED;
                        n_popped = w_link[0].entry;
                        n_count  = r_count - CW'(1);
                        w_op     = CELL_POP;
                    end
                end else if (w_dup) begin
                    n_status = ST_DUPLICATE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + CW'(1);
                    w_op     = CELL_PUSH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;

    // ---- checks ----
    `SUQ_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `SUQ_ASSERT_IMPL(a_zero_unless_pop, o_done && o_status != ST_POPPED, o_popped_value == '0)
    `SUQ_ASSERT_IMPL(a_done_latency, o_done, $past(start && !busy, 4))
    `SUQ_ASSERT_NEXT(a_count_step, !(r_state == S_DONE), $stable(r_count))

endmodule

`default_nettype wire

@@ test/sorted_unique_max_queue_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted unique max queue: testbench
// Sends push and pop commands with random sender gaps and predicts each
// status and popped value from a shadow copy of the sorted store. Every
// o_done result is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module sorted_unique_max_queue_test;

    import suq_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam logic        ACT_PUSH    = 1'b0;
    localparam logic        ACT_POP     = 1'b1;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] popped;
    } t_queue_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_action;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_done;
    logic [STATUS_W-1:0]         o_status;
    logic signed [VALUE_W-1:0]   o_popped_value;

    // shadow of the sorted store, largest first
    logic signed [VALUE_W-1:0]   shadow_entries [QUEUE_DEPTH];
    int                          shadow_count;
    t_queue_result               expected_results [$];
    int                          items_sent;
    int                          results_seen;
    int                          fail_count;

    sorted_unique_max_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_popped_value(o_popped_value)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Update the shadow store for one command and return its result.
    function automatic t_queue_result compute_queue_result(input logic act,
                                                           input logic signed [VALUE_W-1:0] val);
        t_queue_result r;
        bit            found;
        int            slot;
        r.status = ST_INSERTED;
        r.popped = '0;
        found    = 1'b0;
        if (act == ACT_PUSH) begin
            for (int i = 0; i < shadow_count; i++)
                if (shadow_entries[i] == val) found = 1'b1;
            if (found) begin
                r.status = ST_DUPLICATE;
            end else if (shadow_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // first entry smaller than the new value takes its place
                slot = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_entries[i] < val) slot = i;
                for (int i = shadow_count; i > slot; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[slot] = val;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_POPPED;
            r.popped = shadow_entries[0];
            for (int i = 0; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
        end
        return r;
    endfunction

    // Check results first: a result can never belong to a transaction taken
    // at the same edge.
    always @(posedge i_clk) begin
        t_queue_result exp_r;
        if (i_rst_n) begin
            if (o_done) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: status %0d value %0d",
                             $time, o_status, o_popped_value);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_status !== exp_r.status || o_popped_value !== exp_r.popped) begin
                        fail_count++;
                        $display("%0t: expected status %0d value %0d, got status %0d value %0d",
                                 $time, exp_r.status, exp_r.popped, o_status,
                                 o_popped_value);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(compute_queue_result(i_action, i_value));
        end
    end

    task automatic send_command(input logic act, input logic signed [VALUE_W-1:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // Hold off until every outstanding transaction has returned.
    task automatic drain_results();
        start <= 1'b0;
        while (results_seen < items_sent) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = $signed($urandom_range(0, 12)) - 6;
            2: begin
                case ($urandom_range(0, 5))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = VAL_MAX - 1;
                    3: v = VAL_MIN + 1;
                    4: v = '0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_command(input int push_pct);
        if ($urandom_range(1, 100) <= push_pct)
            send_command(ACT_PUSH, pick_value());
        else
            send_command(ACT_POP, $urandom);
    endtask

    task automatic test_empty_store();
        send_command(ACT_POP, $urandom);
        send_command(ACT_PUSH, VAL_MIN);
        send_command(ACT_PUSH, VAL_MIN);
        send_command(ACT_POP, '0);
        send_command(ACT_POP, VAL_MAX);
    endtask

    task automatic test_fill_to_capacity();
        send_command(ACT_PUSH, VAL_MAX);
        send_command(ACT_PUSH, VAL_MIN);
        send_command(ACT_PUSH, '0);
        send_command(ACT_PUSH, -1);
        send_command(ACT_PUSH, 1);
        for (int k = 1; k <= 11; k++)
            send_command(ACT_PUSH, (k % 2) ? 100 * k : -100 * k);
        // duplicate check wins over the full check
        send_command(ACT_PUSH, VAL_MAX);
        send_command(ACT_PUSH, 12345);
    endtask

    task automatic test_random_traffic(input int n_items);
        int push_pct;
        bit with_gaps;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 20;
                endcase
                with_gaps = ($urandom_range(0, 3) != 0);
            end
            if (n == n_items / 2)
                drain_results();
            else if (with_gaps && $urandom_range(0, 2) == 0)
                idle_burst();
            random_command(push_pct);
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        for (int n = 0; n < n_items; n++)
            random_command(60);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = ACT_PUSH;
        i_value      = '0;
        shadow_count = 0;
        items_sent   = 0;
        results_seen = 0;
        fail_count   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_fill_to_capacity();
        test_random_traffic(600);
        test_back_to_back(150);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/suq_pkg.sv
hdl/suq_cell.sv
hdl/sorted_unique_max_queue.sv
test/sorted_unique_max_queue_test.sv
